FILE: hdl/mexp_pkg.sv
// Shared constants, controller states and command/status types for modular exponentiation.
package mexp_pkg;

   localparam int VAL_W            = 31;
   localparam int EXP_W            = 62;
   localparam int EXP_BITS_DEFAULT = 62;
   localparam int PROD_W           = 2 * VAL_W;
   localparam int CNT_W            = 5;

   localparam logic [VAL_W-1:0] MODULUS_RESET = VAL_W'(1000000007);
   localparam logic [CNT_W-1:0] RED_LAST      = CNT_W'(VAL_W - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MUL_R,
      ST_RED_R,
      ST_MUL_S,
      ST_RED_S,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic mul_sel_result;
      logic step;
      logic wb_result;
      logic wb_square;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic base_bad;
      logic exp_zero;
      logic exp_lsb;
      logic red_last;
   } status_type;

endpackage

FILE: hdl/mexp_ifs.sv
// Valid/ready channel interfaces for the request and response items.
interface mexp_req_if;
   logic                          valid;
   logic                          ready;
   logic [mexp_pkg::VAL_W-1:0]    base;
   logic [mexp_pkg::EXP_W-1:0]    exponent;

   modport source (output valid, output base, output exponent, input ready);
   modport sink   (input valid, input base, input exponent, output ready);
endinterface

interface mexp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mexp_pkg::VAL_W-1:0]    power;
   logic                          base_too_large;

   modport source (output valid, output power, output base_too_large, input ready);
   modport sink   (input valid, input power, input base_too_large, output ready);
endinterface

FILE: hdl/mexp_dp.sv
// Datapath: modulus register, operand registers, multiplier and radix-2 remainder unit.
module mexp_dp #(
   parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [mexp_pkg::VAL_W-1:0]   csr_wdata,
   input  logic [mexp_pkg::VAL_W-1:0]   in_base,
   input  logic [mexp_pkg::EXP_W-1:0]   in_exponent,
   input  mexp_pkg::cmd_type            cmd,
   output mexp_pkg::status_type         status,
   output logic [mexp_pkg::VAL_W-1:0]   out_power,
   output logic                         out_base_too_large
);

   logic [mexp_pkg::VAL_W-1:0]  modulus_ff, modulus_in;
   logic [mexp_pkg::VAL_W-1:0]  result_ff, result_in;
   logic [mexp_pkg::VAL_W-1:0]  square_ff, square_in;
   logic [EXP_BITS-1:0]         exp_ff, exp_in;
   logic                        bad_ff, bad_in;
   logic [mexp_pkg::VAL_W-1:0]  rem_ff, rem_in;
   logic [mexp_pkg::VAL_W-1:0]  low_ff, low_in;
   logic [mexp_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [mexp_pkg::VAL_W-1:0]  power_ff, power_in;
   logic                        flag_ff, flag_in;

   logic [mexp_pkg::VAL_W-1:0]  mul_a;
   logic [mexp_pkg::PROD_W-1:0] prod;
   logic [mexp_pkg::VAL_W:0]    trial;
   logic [mexp_pkg::VAL_W:0]    trial_sub;
   logic [mexp_pkg::VAL_W-1:0]  rem_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= mexp_pkg::MODULUS_RESET;
      end else begin
         modulus_ff <= modulus_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
      square_ff <= square_in;
      exp_ff    <= exp_in;
      bad_ff    <= bad_in;
      rem_ff    <= rem_in;
      low_ff    <= low_in;
      cnt_ff    <= cnt_in;
      power_ff  <= power_in;
      flag_ff   <= flag_in;
   end

   assign modulus_in = csr_we ? csr_wdata : modulus_ff;

   assign mul_a     = cmd.mul_sel_result ? result_ff : square_ff;
   assign prod      = mexp_pkg::PROD_W'(mul_a) * mexp_pkg::PROD_W'(square_ff);
   assign trial     = {rem_ff, low_ff[mexp_pkg::VAL_W-1]};
   assign trial_sub = trial - {1'b0, modulus_ff};
   assign rem_next  = (trial >= {1'b0, modulus_ff}) ? trial_sub[mexp_pkg::VAL_W-1:0]
                                                    : trial[mexp_pkg::VAL_W-1:0];

   always_comb begin
      result_in = result_ff;
      square_in = square_ff;
      exp_in    = exp_ff;
      bad_in    = bad_ff;
      rem_in    = rem_ff;
      low_in    = low_ff;
      cnt_in    = cnt_ff;
      power_in  = power_ff;
      flag_in   = flag_ff;
      if (cmd.load) begin
         bad_in    = (in_base >= modulus_ff);
         square_in = in_base;
         result_in = (modulus_ff == mexp_pkg::VAL_W'(1)) ? '0 : mexp_pkg::VAL_W'(1);
         exp_in    = in_exponent[EXP_BITS-1:0];
      end
      if (cmd.mul) begin
         rem_in = prod[mexp_pkg::PROD_W-1:mexp_pkg::VAL_W];
         low_in = prod[mexp_pkg::VAL_W-1:0];
         cnt_in = '0;
      end
      if (cmd.step) begin
         rem_in = rem_next;
         low_in = low_ff << 1;
         cnt_in = cnt_ff + mexp_pkg::CNT_W'(1);
      end
      if (cmd.wb_result) begin
         result_in = rem_next;
      end
      if (cmd.wb_square) begin
         square_in = rem_next;
         exp_in    = exp_ff >> 1;
      end
      if (cmd.out_load) begin
         power_in = bad_ff ? '0 : result_ff;
         flag_in  = bad_ff;
      end
   end

   assign status.base_bad = bad_ff;
   assign status.exp_zero = (exp_ff == '0);
   assign status.exp_lsb  = exp_ff[0];
   assign status.red_last = (cnt_ff == mexp_pkg::RED_LAST);

   assign out_power          = power_ff;
   assign out_base_too_large = flag_ff;

endmodule

FILE: hdl/mexp_ctrl.sv
// Controller: sequences square-and-multiply over the exponent bits and owns the handshakes.
module mexp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  mexp_pkg::status_type  status,
   output mexp_pkg::cmd_type     cmd
);

   mexp_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mexp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mexp_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = mexp_pkg::ST_SCAN;
            end
         end
         mexp_pkg::ST_SCAN: begin
            if (status.base_bad || status.exp_zero) begin
               state_in = mexp_pkg::ST_DONE;
            end else if (status.exp_lsb) begin
               state_in = mexp_pkg::ST_MUL_R;
            end else begin
               state_in = mexp_pkg::ST_MUL_S;
            end
         end
         mexp_pkg::ST_MUL_R: state_in = mexp_pkg::ST_RED_R;
         mexp_pkg::ST_RED_R: begin
            if (status.red_last) begin
               state_in = mexp_pkg::ST_MUL_S;
            end
         end
         mexp_pkg::ST_MUL_S: state_in = mexp_pkg::ST_RED_S;
         mexp_pkg::ST_RED_S: begin
            if (status.red_last) begin
               state_in = mexp_pkg::ST_SCAN;
            end
         end
         mexp_pkg::ST_DONE: begin
            if (slot_free) begin
               state_in = mexp_pkg::ST_IDLE;
            end
         end
         default: state_in = mexp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         mexp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         mexp_pkg::ST_SCAN: ;
         mexp_pkg::ST_MUL_R: begin
            cmd.mul            = 1'b1;
            cmd.mul_sel_result = 1'b1;
         end
         mexp_pkg::ST_RED_R: begin
            cmd.step      = 1'b1;
            cmd.wb_result = status.red_last;
         end
         mexp_pkg::ST_MUL_S: cmd.mul = 1'b1;
         mexp_pkg::ST_RED_S: begin
            cmd.step      = 1'b1;
            cmd.wb_square = status.red_last;
         end
         mexp_pkg::ST_DONE: cmd.out_load = slot_free;
         default: ;
      endcase
   end

   assign rsp_valid_in = cmd.out_load | (rsp_valid_ff & ~rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

endmodule

FILE: hdl/modular_exponentiation.sv
// Top level: base^exponent mod modulus by right-to-left square-and-multiply.
// Each scanned exponent bit takes one multiply (the square) or two (multiply and square);
// scanning stops after the highest set bit.
// A base not below the modulus is answered without any multiply. One item is in work at a time;
// the next is taken while the finished result waits in the output register.
// Each product is reduced by the 31-step radix-2 remainder unit. Synchronous reset sets modulus to 1e9+7.
module modular_exponentiation #(
   parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [mexp_pkg::VAL_W-1:0]  csr_wdata,
   mexp_req_if.sink                    req,
   mexp_rsp_if.source                  rsp
);

   mexp_pkg::cmd_type    cmd;
   mexp_pkg::status_type status;

   mexp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mexp_dp #(
      .EXP_BITS (EXP_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .in_base            (req.base),
      .in_exponent        (req.exponent),
      .cmd                (cmd),
      .status             (status),
      .out_power          (rsp.power),
      .out_base_too_large (rsp.base_too_large)
   );

   a_err_gives_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.base_too_large |-> rsp.power == '0)
      else $error("error result carries a non-zero power");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> !req.ready)
      else $error("new item taken while one is in work");

   a_result_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> $past(!req.ready))
      else $error("result raised without an item in work");

endmodule

FILE: sim/modular_exponentiation_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for modular_exponentiation: directed and random items against a predictor.
module modular_exponentiation_test;

   typedef logic [mexp_pkg::VAL_W-1:0]  value_type;
   typedef logic [mexp_pkg::EXP_W-1:0]  exponent_type;
   typedef logic [mexp_pkg::PROD_W-1:0] wide_type;

   localparam int unsigned  CYCLE_LIMIT  = 3_000_000;
   localparam int unsigned  HOLD_OFF_LEN = 600;
   localparam value_type    MODULUS_MAX  = '1;
   localparam exponent_type EXP_ALL_ONES = '1;

   typedef struct packed {
      value_type power;
      logic      base_too_large;
   } power_result_type;

   logic      clock = 1'b0;
   logic      reset;
   logic      csr_we;
   value_type csr_wdata;

   mexp_req_if req_bus ();
   mexp_rsp_if rsp_bus ();

   value_type        modulus_shadow    = mexp_pkg::MODULUS_RESET;
   power_result_type pending_powers[$];
   int unsigned      error_count       = 0;
   int unsigned      cycle_count       = 0;
   int unsigned      hold_off_requests = 0;
   int unsigned      hold_off_served   = 0;
   int unsigned      hold_off_cycles   = 0;
   bit               send_gaps         = 1'b0;
   bit               accept_stalls     = 1'b0;

   modular_exponentiation DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req       (req_bus),
      .rsp       (rsp_bus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic power_result_type modexp_expected(value_type    base,
                                                        exponent_type exponent,
                                                        value_type    modulus);
      power_result_type outcome;
      wide_type         acc;
      wide_type         square;
      wide_type         modulus_wide;
      outcome.power          = '0;
      outcome.base_too_large = 1'b1;
      modulus_wide           = wide_type'(modulus);
      if (base < modulus) begin
         acc    = wide_type'(1) % modulus_wide;
         square = wide_type'(base);
         for (int i = 0; i < mexp_pkg::EXP_W; i++) begin
            if (exponent[i]) begin
               acc = (acc * square) % modulus_wide;
            end
            square = (square * square) % modulus_wide;
         end
         outcome.power          = acc[mexp_pkg::VAL_W-1:0];
         outcome.base_too_large = 1'b0;
      end
      return outcome;
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   task automatic check_power(value_type power, logic too_large);
      power_result_type want;
      if (pending_powers.size() == 0) begin
         report_mismatch($sformatf("unexpected item, power %0d base_too_large %0b",
                                   power, too_large));
      end else begin
         want = pending_powers.pop_front();
         if (power !== want.power) begin
            report_mismatch($sformatf("power %0d, want %0d", power, want.power));
         end
         if (too_large !== want.base_too_large) begin
            report_mismatch($sformatf("base_too_large %0b, want %0b",
                                      too_large, want.base_too_large));
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         check_power(rsp_bus.power, rsp_bus.base_too_large);
      end
      if (hold_off_served != hold_off_requests) begin
         hold_off_served = hold_off_requests;
         hold_off_cycles = HOLD_OFF_LEN;
      end
      if (hold_off_cycles != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_off_cycles = hold_off_cycles - 1;
      end else begin
         rsp_bus.ready <= !(accept_stalls && $urandom_range(99) < 38);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send_item(value_type base, exponent_type exponent);
      if (send_gaps && $urandom_range(99) < 38) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.base     <= base;
      req_bus.exponent <= exponent;
      do @(posedge clock); while (!req_bus.ready);
      pending_powers.push_back(modexp_expected(base, exponent, modulus_shadow));
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (pending_powers.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_modulus(value_type value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      modulus_shadow = value;
   endtask

   task automatic test_default_modulus();
      send_item(value_type'(0), exponent_type'(0));
      send_item(value_type'(0), exponent_type'(5));
      send_item(value_type'(1), EXP_ALL_ONES);
      send_item(value_type'(2), exponent_type'(10));
      send_item(value_type'(mexp_pkg::MODULUS_RESET - 1), exponent_type'(1));
      send_item(value_type'(mexp_pkg::MODULUS_RESET - 1), exponent_type'(2));
      send_item(mexp_pkg::MODULUS_RESET, exponent_type'(3));
      send_item(MODULUS_MAX, exponent_type'(0));
      send_item(value_type'(123456789), EXP_ALL_ONES);
      send_item(value_type'(987654321), exponent_type'(1) << (mexp_pkg::EXP_W - 1));
      drain_results();
   endtask

   task automatic test_modulus_extremes();
      write_modulus(value_type'(2));
      send_item(value_type'(0), exponent_type'(0));
      send_item(value_type'(1), EXP_ALL_ONES);
      send_item(value_type'(1), exponent_type'(0));
      send_item(value_type'(2), exponent_type'(1));
      drain_results();
      write_modulus(MODULUS_MAX);
      send_item(value_type'(MODULUS_MAX - 1), EXP_ALL_ONES);
      send_item(value_type'(MODULUS_MAX - 1), exponent_type'(2));
      send_item(MODULUS_MAX, exponent_type'(1));
      drain_results();
   endtask

   task automatic test_modulus_zero_one();
      write_modulus(value_type'(0));
      send_item(value_type'(0), exponent_type'(0));
      send_item(value_type'(5), exponent_type'(7));
      drain_results();
      write_modulus(value_type'(1));
      send_item(value_type'(0), exponent_type'(0));
      send_item(value_type'(0), EXP_ALL_ONES);
      send_item(value_type'(1), exponent_type'(1));
      drain_results();
   endtask

   task automatic test_backpressure();
      write_modulus(value_type'($urandom_range(32'd1 << 20, MODULUS_MAX)));
      send_gaps     = 1'b0;
      accept_stalls = 1'b0;
      hold_off_requests++;
      repeat (6) begin
         send_item(value_type'($urandom_range(0, modulus_shadow - 1)),
                   exponent_type'($urandom_range(0, 15)));
      end
      drain_results();
   endtask

   task automatic test_random();
      value_type   base;
      logic [63:0] raw;
      int unsigned bit_count;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: write_modulus(value_type'($urandom_range(32'd1 << 30, MODULUS_MAX)));
            1: write_modulus(value_type'($urandom_range(2, 64)));
            2: write_modulus(MODULUS_MAX);
            default: write_modulus(value_type'($urandom_range(2, MODULUS_MAX)));
         endcase
         send_gaps     = (phase != 1);
         accept_stalls = (phase != 1);
         repeat (26) begin
            if ($urandom_range(9) == 0) begin
               base = value_type'($urandom_range(modulus_shadow, MODULUS_MAX));
            end else begin
               base = value_type'($urandom_range(0, modulus_shadow - 1));
            end
            bit_count = ($urandom_range(7) == 0) ? mexp_pkg::EXP_W
                                                 : $urandom_range(0, mexp_pkg::EXP_W);
            raw       = {$urandom, $urandom};
            raw       = raw >> (64 - bit_count);
            send_item(base, raw[mexp_pkg::EXP_W-1:0]);
         end
         drain_results();
      end
   endtask

   initial begin
      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_wdata         <= '0;
      req_bus.valid     <= 1'b0;
      req_bus.base      <= '0;
      req_bus.exponent  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_modulus();
      test_modulus_extremes();
      test_modulus_zero_one();
      test_backpressure();
      test_random();
      drain_results();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
